FILE: hdl/mark_pkg.sv
// Shared types and constants for the minimum-area k-point rectangle search.
package mark_pkg;

  localparam int AREA_BITS = 63;
  localparam int KMIN_BITS = 7;
  localparam logic [AREA_BITS-1:0] AREA_MAX = {AREA_BITS{1'b1}};
  localparam logic [KMIN_BITS-1:0] KMIN_RESET = 7'd2;
  localparam logic [KMIN_BITS-1:0] KMIN_FLOOR = 7'd2;

  typedef enum logic [4:0] {
    S_LOAD,
    S_SI, S_SK, S_SC, S_SW,
    S_LI, S_LK, S_RI, S_RK,
    S_IC, S_IW, S_IE,
    S_HC, S_DI, S_DC, S_MU, S_CM,
    S_DONE
  } state_t;

endpackage

FILE: hdl/mark_area.sv
// Shared area unit: registered height times width with saturation.
module mark_area
  import mark_pkg::*;
#(
  parameter int COORD_BITS = 31
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [COORD_BITS-1:0] dy,
  input  logic [COORD_BITS-1:0] dx,
  output logic [AREA_BITS-1:0]  area
);

  localparam int PW = 2 * COORD_BITS;
  localparam int EW = (PW > AREA_BITS) ? PW : AREA_BITS;

  logic [PW-1:0] prod;
  logic [EW-1:0] prod_w;

  // Hold the product for the compare step
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= dy * dx;
    end
  end

  // Clamp anything above the largest representable area
  always_comb begin
    prod_w = EW'(prod);
    if (prod_w > EW'(AREA_MAX)) begin
      area = AREA_MAX;
    end else begin
      area = prod_w[AREA_BITS-1:0];
    end
  end

endmodule

FILE: hdl/min_area_rect_k_points.sv
// Loading: a point is taken every cycle while loading; the last point starts the search.
// Search: insertion sort of the point store, shifting one point at a time, then for each
// left/right pair an insertion into the sorted span store, a scan for the top bound once the
// span holds k points, and a check of each candidate window through the shared multiplier.
// One result per set; the next set loads while a result waits to be taken.
// Reset (synchronous, rst high) empties the set, clears flags and sets kmin to 2.
module min_area_rect_k_points
  import mark_pkg::*;
#(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 31
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [COORD_BITS-1:0] x_coord,
  input  logic signed [COORD_BITS-1:0] y_coord,
  input  logic                        last,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [AREA_BITS-1:0]        min_area,
  output logic                        found,
  output logic                        overflow,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [KMIN_BITS-1:0]        cfg_data
);

  localparam int CW   = COORD_BITS;
  localparam int IW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNTW = $clog2(MAX_POINTS + 1);
  localparam int CMPW = ((CNTW > KMIN_BITS) ? CNTW : KMIN_BITS) + 2;

  state_t state, state_next;
  logic [CNTW-1:0] count, count_next, i, i_next, j, j_next;
  logic [CNTW-1:0] l, l_next, r, r_next, len, len_next, h, h_next, d, d_next;
  logic dropped, dropped_next, any, any_next;
  logic [KMIN_BITS-1:0] kmin, kp;
  logic signed [CW-1:0] key_x, key_x_next, key_y, key_y_next;
  logic signed [CW-1:0] lx, lx_next, ly, ly_next, ylo, ylo_next, yhi, yhi_next;
  logic [CW-1:0] dx, dx_next, dy, dy_next;
  logic [AREA_BITS-1:0] best, best_next, area;
  logic [AREA_BITS-1:0] res_area, res_area_next;
  logic res_found, res_found_next, res_ovf, res_ovf_next, out_valid_next;
  logic res_valid_q;

  // point store and span store
  logic [2*CW-1:0] pts_mem [MAX_POINTS];
  logic [2*CW-1:0] pts_wd, pts_rd;
  logic [IW-1:0] pts_wa, pts_ra;
  logic pts_we;
  logic signed [CW-1:0] span_mem [MAX_POINTS];
  logic signed [CW-1:0] span_wd, span_rd0, span_rd1;
  logic [IW-1:0] span_wa, span_ra0, span_ra1;
  logic span_we;

  logic signed [CW-1:0] rd_x, rd_y;
  logic gt;
  logic [CNTW-1:0] jn;
  logic [CMPW-1:0] du, u;

  assign rd_x = pts_rd[2*CW-1:CW];
  assign rd_y = pts_rd[CW-1:0];
  assign kp = (kmin < KMIN_FLOOR) ? KMIN_FLOOR : kmin;
  assign in_ready = (state == S_LOAD);
  assign cfg_ready = 1'b1;
  assign out_valid = res_valid_q;
  assign min_area = res_area;
  assign found = res_found;
  assign overflow = res_ovf;

  mark_area #(.COORD_BITS(CW)) u_area (
    .clk  (clk),
    .en   (state == S_MU),
    .dy   (dy),
    .dx   (dx),
    .area (area)
  );

  // Memories: one write and registered reads
  always_ff @(posedge clk) begin
    if (pts_we) begin
      pts_mem[pts_wa] <= pts_wd;
    end
    pts_rd <= pts_mem[pts_ra];
  end

  always_ff @(posedge clk) begin
    if (span_we) begin
      span_mem[span_wa] <= span_wd;
    end
    span_rd0 <= span_mem[span_ra0];
    span_rd1 <= span_mem[span_ra1];
  end

  // Sequencer: next state and datapath controls
  always_comb begin
    state_next = state;
    count_next = count;  dropped_next = dropped;
    i_next = i;  j_next = j;  l_next = l;  r_next = r;
    len_next = len;  h_next = h;  d_next = d;  any_next = any;
    key_x_next = key_x;  key_y_next = key_y;
    lx_next = lx;  ly_next = ly;  ylo_next = ylo;  yhi_next = yhi;
    dx_next = dx;  dy_next = dy;  best_next = best;
    res_area_next = res_area;  res_found_next = res_found;  res_ovf_next = res_ovf;
    out_valid_next = res_valid_q && !out_ready;
    pts_we = 1'b0;  pts_wa = '0;  pts_wd = {key_x, key_y};  pts_ra = '0;
    span_we = 1'b0;  span_wa = '0;  span_wd = key_y;  span_ra0 = '0;  span_ra1 = '0;
    gt = (rd_x > key_x) || ((rd_x == key_x) && (rd_y > key_y));
    jn = j - CNTW'(1);
    du = CMPW'(d) + CMPW'(kp) - CMPW'(1);
    u = (du > CMPW'(h)) ? du : CMPW'(h);
    case (state)
      S_LOAD: begin
        // store the beat, or drop it when full
        if (in_valid) begin
          if (count < CNTW'(MAX_POINTS)) begin
            pts_we = 1'b1;
            pts_wa = count[IW-1:0];
            pts_wd = {x_coord, y_coord};
            count_next = count + CNTW'(1);
          end else begin
            dropped_next = 1'b1;
          end
          if (last) begin
            i_next = CNTW'(1);
            any_next = 1'b0;
            best_next = '0;
            state_next = S_SI;
          end
        end
      end
      S_SI: begin
        if (i >= count) begin
          l_next = '0;
          state_next = S_LI;
        end else begin
          pts_ra = i[IW-1:0];
          state_next = S_SK;
        end
      end
      S_SK: begin
        key_x_next = rd_x;
        key_y_next = rd_y;
        j_next = i;
        pts_ra = IW'(i - CNTW'(1));
        state_next = S_SC;
      end
      S_SC: begin
        // shift the larger point up, or drop the key into place
        pts_we = 1'b1;
        pts_wa = j[IW-1:0];
        if (gt) begin
          pts_wd = pts_rd;
          j_next = jn;
          if (jn == '0) begin
            state_next = S_SW;
          end else begin
            pts_ra = IW'(jn - CNTW'(1));
          end
        end else begin
          i_next = i + CNTW'(1);
          state_next = S_SI;
        end
      end
      S_SW: begin
        pts_we = 1'b1;
        pts_wa = '0;
        i_next = i + CNTW'(1);
        state_next = S_SI;
      end
      S_LI: begin
        if ((l + CNTW'(1)) >= count) begin
          state_next = S_DONE;
        end else begin
          pts_ra = l[IW-1:0];
          state_next = S_LK;
        end
      end
      S_LK: begin
        lx_next = rd_x;
        ly_next = rd_y;
        span_we = 1'b1;
        span_wa = '0;
        span_wd = rd_y;
        len_next = CNTW'(1);
        r_next = l + CNTW'(1);
        state_next = S_RI;
      end
      S_RI: begin
        if (r >= count) begin
          l_next = l + CNTW'(1);
          state_next = S_LI;
        end else begin
          pts_ra = r[IW-1:0];
          state_next = S_RK;
        end
      end
      S_RK: begin
        key_y_next = rd_y;
        ylo_next = (ly < rd_y) ? ly : rd_y;
        yhi_next = (ly < rd_y) ? rd_y : ly;
        dx_next = CW'(rd_x - lx);
        j_next = len;
        span_ra0 = IW'(len - CNTW'(1));
        state_next = S_IC;
      end
      S_IC: begin
        // insert the right edge y into the sorted span
        span_we = 1'b1;
        span_wa = j[IW-1:0];
        if (span_rd0 > key_y) begin
          span_wd = span_rd0;
          j_next = jn;
          if (jn == '0) begin
            state_next = S_IW;
          end else begin
            span_ra0 = IW'(jn - CNTW'(1));
          end
        end else begin
          len_next = len + CNTW'(1);
          state_next = S_IE;
        end
      end
      S_IW: begin
        span_we = 1'b1;
        span_wa = '0;
        len_next = len + CNTW'(1);
        state_next = S_IE;
      end
      S_IE: begin
        if (CMPW'(len) < CMPW'(kp)) begin
          r_next = r + CNTW'(1);
          state_next = S_RI;
        end else begin
          h_next = '0;
          span_ra0 = '0;
          state_next = S_HC;
        end
      end
      S_HC: begin
        // find the first span entry reaching the top bound
        if (span_rd0 >= yhi) begin
          d_next = '0;
          state_next = S_DI;
        end else begin
          h_next = h + CNTW'(1);
          span_ra0 = IW'(h + CNTW'(1));
        end
      end
      S_DI: begin
        if (u >= CMPW'(len)) begin
          r_next = r + CNTW'(1);
          state_next = S_RI;
        end else begin
          span_ra0 = d[IW-1:0];
          span_ra1 = u[IW-1:0];
          state_next = S_DC;
        end
      end
      S_DC: begin
        if (span_rd0 > ylo) begin
          r_next = r + CNTW'(1);
          state_next = S_RI;
        end else begin
          dy_next = CW'(span_rd1 - span_rd0);
          state_next = S_MU;
        end
      end
      S_MU: begin
        state_next = S_CM;
      end
      S_CM: begin
        // keep the least area
        if (!any || (area < best)) begin
          best_next = area;
        end
        any_next = 1'b1;
        d_next = d + CNTW'(1);
        state_next = S_DI;
      end
      S_DONE: begin
        if (!res_valid_q) begin
          res_area_next = any ? best : '0;
          res_found_next = any;
          res_ovf_next = dropped;
          out_valid_next = 1'b1;
          count_next = '0;
          dropped_next = 1'b0;
          state_next = S_LOAD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;  dropped <= 1'b0;  any <= 1'b0;  res_valid_q <= 1'b0;
      i <= '0;  j <= '0;  l <= '0;  r <= '0;  len <= '0;  h <= '0;  d <= '0;
      kmin <= KMIN_RESET;
    end else begin
      count <= count_next;  dropped <= dropped_next;  any <= any_next;
      res_valid_q <= out_valid_next;
      i <= i_next;  j <= j_next;  l <= l_next;  r <= r_next;
      len <= len_next;  h <= h_next;  d <= d_next;
      if (cfg_valid) begin
        kmin <= cfg_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    key_x <= key_x_next;  key_y <= key_y_next;
    lx <= lx_next;  ly <= ly_next;  ylo <= ylo_next;  yhi <= yhi_next;
    dx <= dx_next;  dy <= dy_next;  best <= best_next;
    res_area <= res_area_next;  res_found <= res_found_next;  res_ovf <= res_ovf_next;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNTW'(MAX_POINTS))
    else $error("point count beyond store depth");

  a_last_starts: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last |=> state == S_SI)
    else $error("last beat did not start the sort");

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> min_area == '0)
    else $error("area given without a rectangle");

  a_span_len: assert property (@(posedge clk) disable iff (rst)
    state == S_DI |-> len <= count)
    else $error("span longer than point set");

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for the minimum-area k-point rectangle search.
module tb_top
  import mark_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_PTS = 64;
  localparam int CB = 31;

  typedef struct packed {
    logic [AREA_BITS-1:0] area;
    logic                 hit;
    logic                 ovf;
  } rect_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic signed [CB-1:0]  x_coord = '0;
  logic signed [CB-1:0]  y_coord = '0;
  logic                  last = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [AREA_BITS-1:0]  min_area;
  logic                  found;
  logic                  overflow;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [KMIN_BITS-1:0]  cfg_data = '0;

  // predictor state
  longint       set_x[MAX_PTS];
  longint       set_y[MAX_PTS];
  int           set_len;
  bit           set_dropped;
  int           kmin;
  rect_result_t pending_rects[$];

  int send_idle_pct;
  int recv_stall_pct;
  int mismatches;

  min_area_rect_k_points #(.MAX_POINTS(MAX_PTS), .COORD_BITS(CB)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .x_coord(x_coord), .y_coord(y_coord), .last(last),
    .out_valid(out_valid), .out_ready(out_ready),
    .min_area(min_area), .found(found), .overflow(overflow),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Search the closed set for the least enclosing rectangle
  function automatic rect_result_t search_rect();
    rect_result_t res;
    longint xs[MAX_PTS];
    longint ys[MAX_PTS];
    longint span[MAX_PTS];
    longint kx, ky, ylo, yhi, dx, a, best;
    int j, m, k;
    bit any;
    k = (kmin < 2) ? 2 : kmin;
    any = 0;
    best = 0;
    for (int i = 0; i < set_len; i++) begin
      xs[i] = set_x[i];
      ys[i] = set_y[i];
    end
    // order by x then y
    for (int i = 1; i < set_len; i++) begin
      kx = xs[i];
      ky = ys[i];
      j = i;
      while (j > 0 && (xs[j-1] > kx || (xs[j-1] == kx && ys[j-1] > ky))) begin
        xs[j] = xs[j-1];
        ys[j] = ys[j-1];
        j--;
      end
      xs[j] = kx;
      ys[j] = ky;
    end
    for (int r = 0; r < set_len; r++) begin
      for (int l = 0; l < r; l++) begin
        m = r - l + 1;
        if (m >= k) begin
          for (int i = 0; i < m; i++) span[i] = ys[l+i];
          for (int i = 1; i < m; i++) begin
            ky = span[i];
            j = i;
            while (j > 0 && span[j-1] > ky) begin
              span[j] = span[j-1];
              j--;
            end
            span[j] = ky;
          end
          ylo = (ys[l] < ys[r]) ? ys[l] : ys[r];
          yhi = (ys[l] < ys[r]) ? ys[r] : ys[l];
          dx = xs[r] - xs[l];
          for (int u = 0; u < m; u++) begin
            for (int d = 0; d < u; d++) begin
              if (u - d + 1 >= k && span[d] <= ylo && span[u] >= yhi) begin
                a = (span[u] - span[d]) * dx;
                if (!any || a < best) best = a;
                any = 1;
              end
            end
          end
        end
      end
    end
    res.area = any ? best[AREA_BITS-1:0] : '0;
    res.hit = any;
    res.ovf = set_dropped;
    return res;
  endfunction

  // Record an accepted point and close the set on last
  function automatic void take_point(logic [CB-1:0] xv, logic [CB-1:0] yv, logic lst);
    if (set_len < MAX_PTS) begin
      set_x[set_len] = longint'(signed'(xv));
      set_y[set_len] = longint'(signed'(yv));
      set_len++;
    end else begin
      set_dropped = 1;
    end
    if (lst) begin
      pending_rects = {pending_rects, search_rect()};
      set_len = 0;
      set_dropped = 0;
    end
  endfunction

  // Send one point beat; valid stays high on return
  task automatic send_point(logic [CB-1:0] xv, logic [CB-1:0] yv, logic lst);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    end
    in_valid <= 1'b1;
    x_coord <= xv;
    y_coord <= yv;
    last <= lst;
    do @(posedge clk); while (!in_ready);
    take_point(xv, yv, lst);
    @(negedge clk);
  endtask

  // Drop valid and wait for every pending result, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_rects.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_kmin(int k);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= k[KMIN_BITS-1:0];
    do @(posedge clk); while (!cfg_ready);
    kmin = k;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [CB-1:0] rand_coord(bit narrow);
    logic [CB-1:0] v;
    if (narrow) v = CB'($urandom_range(16) - 8);
    else v = CB'($urandom());
    return v;
  endfunction

  task automatic send_set(int n, bit narrow);
    for (int i = 0; i < n; i++)
      send_point(rand_coord(narrow), rand_coord(narrow), i == n - 1);
  endtask

  // Ready pattern and result check
  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    rect_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_rects.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat area=%0d", min_area);
      end else begin
        want = pending_rects.pop_front();
        if (min_area !== want.area || found !== want.hit || overflow !== want.ovf) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp area=%0d found=%0b ovf=%0b got area=%0d found=%0b ovf=%0b",
                     want.area, want.hit, want.ovf, min_area, found, overflow);
        end
      end
    end
  end

  task automatic test_directed();
    logic [CB-1:0] xmin, xmax;
    xmin = {1'b1, {(CB-1){1'b0}}};
    xmax = {1'b0, {(CB-1){1'b1}}};
    send_idle_pct = 0;
    recv_stall_pct = 0;
    // lone point: nothing can qualify
    send_point(CB'(5), CB'(7), 1'b1);
    // two points, then two identical points
    send_point(CB'(1), CB'(2), 1'b0);
    send_point(CB'(4), CB'(9), 1'b1);
    send_point(CB'(3), CB'(3), 1'b0);
    send_point(CB'(3), CB'(3), 1'b1);
    // opposite corners of the coordinate range
    send_point(xmin, xmin, 1'b0);
    send_point(xmax, xmax, 1'b1);
    send_point(xmax, xmin, 1'b0);
    send_point(xmin, xmax, 1'b0);
    send_point(CB'(0), CB'(0), 1'b1);
    // k above the set size
    write_kmin(64);
    send_set(5, 1'b0);
    // full store with k equal to the store depth
    send_set(64, 1'b1);
    // store overflows, including the last point
    write_kmin(60);
    send_set(66, 1'b0);
    write_kmin(3);
    send_set(6, 1'b1);
    // k below two acts as two
    write_kmin(0);
    send_set(7, 1'b1);
    // k beyond the store depth
    write_kmin(127);
    send_set(4, 1'b1);
    drain();
  endtask

  task automatic test_random(int idle, int stall, int items);
    int sent, n;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(9) == 0) write_kmin($urandom_range(2, 64));
      else if ($urandom_range(3) == 0) write_kmin($urandom_range(2, 5));
      n = $urandom_range(1, 8);
      send_set(n, 1'($urandom_range(1)));
      sent += n;
    end
    drain();
  endtask

  initial begin
    set_len = 0;
    set_dropped = 0;
    kmin = KMIN_RESET;
    mismatches = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_random(0, 0, 375);
    test_random(60, 0, 375);
    test_random(0, 60, 375);
    test_random(8, 8, 375);
    write_kmin(2);
    drain();
    if (mismatches == 0 && pending_rects.size() == 0) $display("PASS min_area_rect_k_points");
    else $display("FAIL min_area_rect_k_points");
    $finish;
  end

  // Guard against a hung block
  initial begin
    #200ms;
    $display("FAIL min_area_rect_k_points");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/mark_pkg.sv
hdl/mark_area.sv
hdl/min_area_rect_k_points.sv
verif/tb_top.sv
